// ===== design/wte_pkg.sv =====
// ----------------------------------------------------------------------------
// wte_pkg: shared definitions for the wall tilt estimator
// Default sizes, register indexes, the controller states and the control word
// that steers a row of insertion cells.
// ----------------------------------------------------------------------------
package wte_pkg;

	localparam int KEEP_COUNT_DEF = 10;
	localparam int COORD_BITS_DEF = 16;
	localparam int WALL_MARGIN    = 2;
	localparam int DIST_W         = 15;
	localparam int TILT_W         = 16;
	localparam int CFG_IDX_W      = 1;

	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DIST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_DIST  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_LAUNCH,
		ST_DIVIDE
	} state_t;

	// Control word for one row: insert the current point, or shift every
	// entry one place toward the tail.
	typedef struct packed {
		logic ins_en;
		logic shift;
	} row_ctrl_t;

endpackage

// ===== design/wte_cell.sv =====
// ----------------------------------------------------------------------------
// wte_cell: one entry of a sorted insertion row
// Holds one kept point and decides each cycle whether to keep it, take the new
// point, or take the entry of its upstream neighbor.
// ----------------------------------------------------------------------------
module wte_cell #(
	parameter int COORD_BITS = wte_pkg::COORD_BITS_DEF,
	parameter bit WANT_HIGH  = 1'b1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wte_pkg::row_ctrl_t           ctrl,
	input  logic signed [COORD_BITS-1:0] new_x,
	input  logic signed [COORD_BITS-1:0] new_y,
	input  logic                         prev_valid,
	input  logic signed [COORD_BITS-1:0] prev_x,
	input  logic signed [COORD_BITS-1:0] prev_y,
	input  logic                         prev_ins,
	output logic                         valid,
	output logic signed [COORD_BITS-1:0] x,
	output logic signed [COORD_BITS-1:0] y,
	output logic                         ins
);
	import wte_pkg::*;

	logic                         valid_q;
	logic signed [COORD_BITS-1:0] x_q;
	logic signed [COORD_BITS-1:0] y_q;
	logic                         beats;
	logic                         take_prev;
	logic                         take_new;

	// A strict compare: an equal y never displaces the earlier point.
	assign beats     = WANT_HIGH ? (new_y > y_q) : (new_y < y_q);
	assign ins       = !valid_q || beats;
	assign take_prev = ctrl.shift || (ctrl.ins_en && prev_ins);
	assign take_new  = ctrl.ins_en && !prev_ins && ins;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_prev) begin
			valid_q <= prev_valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_prev) begin
			x_q <= prev_x;
			y_q <= prev_y;
		end else if (take_new) begin
			x_q <= new_x;
			y_q <= new_y;
		end
	end

	assign valid = valid_q;
	assign x     = x_q;
	assign y     = y_q;

endmodule

// ===== design/wte_row.sv =====
// ----------------------------------------------------------------------------
// wte_row: a row of insertion cells for one kept list
// Keeps the points sorted by y, best first; the tail cell feeds the summing
// logic while the row is drained.
// ----------------------------------------------------------------------------
module wte_row #(
	parameter int KEEP_COUNT = wte_pkg::KEEP_COUNT_DEF,
	parameter int COORD_BITS = wte_pkg::COORD_BITS_DEF,
	parameter bit WANT_HIGH  = 1'b1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wte_pkg::row_ctrl_t           ctrl,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         tail_valid,
	output logic signed [COORD_BITS-1:0] tail_x
);
	import wte_pkg::*;

	logic                         chain_valid [0:KEEP_COUNT];
	logic signed [COORD_BITS-1:0] chain_x     [0:KEEP_COUNT];
	logic signed [COORD_BITS-1:0] chain_y     [0:KEEP_COUNT];
	logic                         chain_ins   [0:KEEP_COUNT];

	// The head cell sees an empty neighbor that never claims the new point.
	assign chain_valid[0] = 1'b0;
	assign chain_x[0]     = '0;
	assign chain_y[0]     = '0;
	assign chain_ins[0]   = 1'b0;

	for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
		wte_cell #(
			.COORD_BITS (COORD_BITS),
			.WANT_HIGH  (WANT_HIGH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_x      (point_x),
			.new_y      (point_y),
			.prev_valid (chain_valid[i]),
			.prev_x     (chain_x[i]),
			.prev_y     (chain_y[i]),
			.prev_ins   (chain_ins[i]),
			.valid      (chain_valid[i+1]),
			.x          (chain_x[i+1]),
			.y          (chain_y[i+1]),
			.ins        (chain_ins[i+1])
		);
	end

	assign tail_valid = chain_valid[KEEP_COUNT];
	assign tail_x     = chain_x[KEEP_COUNT];

endmodule

// ===== design/wte_div.sv =====
// ----------------------------------------------------------------------------
// wte_div: divider by a fixed divisor
// Registers the dividend, then forms the quotient by multiplying with a
// rounded-up reciprocal, with the quotient saturated to the tilt width.
// ----------------------------------------------------------------------------
module wte_div #(
	parameter int DIVISOR = wte_pkg::KEEP_COUNT_DEF,
	parameter int IN_W    = 21
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [IN_W-1:0]            dividend,
	output logic                       done,
	output logic [wte_pkg::TILT_W-1:0] quotient
);
	import wte_pkg::*;

	// With the shift at IN_W plus the ceiling of log2 of the divisor, the rounding error
	// of the reciprocal stays below one quotient step for every dividend.
	localparam int SHIFT   = IN_W + $clog2(DIVISOR);
	localparam int RECIP_W = IN_W + 1;
	localparam int PROD_W  = IN_W + RECIP_W;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

	logic [IN_W-1:0]   mag_q;
	logic              run_q;
	logic              done_q;
	logic [TILT_W-1:0] quot_q;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] qwide;
	logic              sat;

	assign prod  = PROD_W'(mag_q) * PROD_W'(RECIP_W'(RECIP));
	assign qwide = prod >> SHIFT;
	assign sat   = qwide > PROD_W'({TILT_W{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q  <= start;
			done_q <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend;
		end
		if (run_q) begin
			quot_q <= sat ? {TILT_W{1'b1}} : qwide[TILT_W-1:0];
		end
	end

	assign quotient = quot_q;
	assign done     = done_q;

endmodule

// ===== design/wall_tilt_estimator_top.sv =====
// ----------------------------------------------------------------------------
// wall_tilt_estimator_top: side wall tilt from one lidar scan
// Sorts wall points into four rows of insertion cells and, at the end of a
// scan, reports the magnitude of the mean x difference between top and bottom points per side.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+---------------------------
//  point in | point_x, point_y, scan_end                   | start high, busy low
//  result   | right_tilt, left_tilt, right_valid, left_valid| done high for one cycle
//  config   | cfg_index, cfg_data                          | cfg_we high, no wait
//
// A point without scan_end leaves busy low, so such points may arrive on every
// cycle: the rows insert in parallel, each cell comparing against the new y. A
// word with scan_end keeps busy high while the rows drain through their tail
// cells into an accumulator until every entry has been added, the launch state
// loads the magnitudes into the dividers, the dividers form the quotients by
// reciprocal multiplication, and the result word is registered. The result
// word is then valid on the outputs in the single cycle that done is high, right
// after busy falls, and the receiver cannot stall it. Reset clears the rows,
// the counts, the wall distances and the controller; draining leaves the rows
// empty.
//
module wall_tilt_estimator_top #(
	parameter int KEEP_COUNT = wte_pkg::KEEP_COUNT_DEF,
	parameter int COORD_BITS = wte_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic                          scan_end,
	output logic                          done,
	output logic [wte_pkg::TILT_W-1:0]    right_tilt,
	output logic [wte_pkg::TILT_W-1:0]    left_tilt,
	output logic                          right_valid,
	output logic                          left_valid,
	input  logic                          cfg_we,
	input  logic [wte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wte_pkg::DIST_W-1:0]    cfg_data
);
	import wte_pkg::*;

	// Compare width wide enough for a coordinate and a threshold with margin.
	localparam int CW    = ((COORD_BITS > DIST_W) ? COORD_BITS : DIST_W) + 2;
	// The top-minus-bottom sum, signed, and its magnitude.
	localparam int SUM_W = COORD_BITS + $clog2(KEEP_COUNT) + 2;
	localparam int ABS_W = SUM_W - 1;
	localparam int DW    = $clog2(KEEP_COUNT + 1);

	localparam logic signed [CW-1:0] MARGIN_S = CW'(WALL_MARGIN);

	state_t state_q, state_d;

	logic [DIST_W-1:0]       rdist_q, ldist_q;
	logic [DW-1:0]           rcnt_q, lcnt_q;
	logic [DW-1:0]           drain_cnt_q;
	logic                    rv_q, lv_q;
	logic signed [SUM_W-1:0] racc_q, lacc_q;
	logic                    done_q;
	logic [TILT_W-1:0]       rtilt_q, ltilt_q;

	logic                    accept;
	logic signed [CW-1:0]    xe;
	logic signed [CW-1:0]    rdist_s, ldist_s;
	logic signed [CW-1:0]    rthr, lthr;
	logic                    is_right, is_left;
	logic                    drain_last;
	logic                    div_start;
	row_ctrl_t               rctrl, lctrl;

	logic                         rt_valid, rb_valid, lt_valid, lb_valid;
	logic signed [COORD_BITS-1:0] rt_x, rb_x, lt_x, lb_x;
	logic signed [SUM_W-1:0]      rt_term, rb_term, lt_term, lb_term;
	logic signed [SUM_W-1:0]      rmag, lmag;
	logic                         rdiv_done, ldiv_done;
	logic [TILT_W-1:0]            rquot, lquot;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Wall classification, all in signed arithmetic so that a distance below
	// the margin gives a correctly signed threshold rather than a wrapped one.
	assign xe       = CW'(point_x);
	assign rdist_s  = {{(CW-DIST_W){1'b0}}, rdist_q};
	assign ldist_s  = {{(CW-DIST_W){1'b0}}, ldist_q};
	assign rthr     = rdist_s - MARGIN_S;
	assign lthr     = MARGIN_S - ldist_s;
	assign is_right = !xe[CW-1] && (xe != '0) && (xe >= rthr);
	assign is_left  = xe[CW-1] && (xe >= lthr);

	assign rctrl.ins_en = accept && is_right;
	assign rctrl.shift  = (state_q == ST_DRAIN);
	assign lctrl.ins_en = accept && is_left;
	assign lctrl.shift  = (state_q == ST_DRAIN);

	wte_row #(.KEEP_COUNT(KEEP_COUNT), .COORD_BITS(COORD_BITS), .WANT_HIGH(1'b1)) u_right_top (
		.clk(clk), .arst_n(arst_n), .ctrl(rctrl), .point_x(point_x), .point_y(point_y),
		.tail_valid(rt_valid), .tail_x(rt_x)
	);
	wte_row #(.KEEP_COUNT(KEEP_COUNT), .COORD_BITS(COORD_BITS), .WANT_HIGH(1'b0)) u_right_bot (
		.clk(clk), .arst_n(arst_n), .ctrl(rctrl), .point_x(point_x), .point_y(point_y),
		.tail_valid(rb_valid), .tail_x(rb_x)
	);
	wte_row #(.KEEP_COUNT(KEEP_COUNT), .COORD_BITS(COORD_BITS), .WANT_HIGH(1'b1)) u_left_top (
		.clk(clk), .arst_n(arst_n), .ctrl(lctrl), .point_x(point_x), .point_y(point_y),
		.tail_valid(lt_valid), .tail_x(lt_x)
	);
	wte_row #(.KEEP_COUNT(KEEP_COUNT), .COORD_BITS(COORD_BITS), .WANT_HIGH(1'b0)) u_left_bot (
		.clk(clk), .arst_n(arst_n), .ctrl(lctrl), .point_x(point_x), .point_y(point_y),
		.tail_valid(lb_valid), .tail_x(lb_x)
	);

	// Empty cells add nothing to the sums.
	assign rt_term = rt_valid ? SUM_W'(rt_x) : '0;
	assign rb_term = rb_valid ? SUM_W'(rb_x) : '0;
	assign lt_term = lt_valid ? SUM_W'(lt_x) : '0;
	assign lb_term = lb_valid ? SUM_W'(lb_x) : '0;

	assign rmag = racc_q[SUM_W-1] ? -racc_q : racc_q;
	assign lmag = lacc_q[SUM_W-1] ? -lacc_q : lacc_q;

	assign drain_last = (drain_cnt_q == DW'(KEEP_COUNT - 1));

	// Controller: idle while points stream in, then drain, load, divide.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_last) begin
					state_d = ST_LAUNCH;
				end
			end
			ST_LAUNCH: begin
				div_start = 1'b1;
				state_d   = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (rdiv_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	wte_div #(.DIVISOR(KEEP_COUNT), .IN_W(ABS_W)) u_right_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(rmag[ABS_W-1:0]),
		.done(rdiv_done), .quotient(rquot)
	);
	wte_div #(.DIVISOR(KEEP_COUNT), .IN_W(ABS_W)) u_left_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(lmag[ABS_W-1:0]),
		.done(ldiv_done), .quotient(lquot)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdist_q <= '0;
			ldist_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RIGHT_DIST: rdist_q <= cfg_data;
				REG_LEFT_DIST:  ldist_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Saturating seen counts; on the last word the valid flags include the
	// point that carries scan_end, and the counts start over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
			lcnt_q <= '0;
			rv_q   <= 1'b0;
			lv_q   <= 1'b0;
		end else if (accept) begin
			if (scan_end) begin
				rcnt_q <= '0;
				lcnt_q <= '0;
				rv_q   <= (rcnt_q == DW'(KEEP_COUNT)) ||
				          (is_right && (rcnt_q == DW'(KEEP_COUNT - 1)));
				lv_q   <= (lcnt_q == DW'(KEEP_COUNT)) ||
				          (is_left && (lcnt_q == DW'(KEEP_COUNT - 1)));
			end else begin
				if (is_right && (rcnt_q != DW'(KEEP_COUNT))) begin
					rcnt_q <= rcnt_q + DW'(1);
				end
				if (is_left && (lcnt_q != DW'(KEEP_COUNT))) begin
					lcnt_q <= lcnt_q + DW'(1);
				end
			end
		end
	end

	// Drain counter and the running top-minus-bottom sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_cnt_q <= '0;
		end else if (state_q == ST_DRAIN) begin
			drain_cnt_q <= drain_last ? '0 : drain_cnt_q + DW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && scan_end) begin
			racc_q <= '0;
			lacc_q <= '0;
		end else if (state_q == ST_DRAIN) begin
			racc_q <= racc_q + rt_term - rb_term;
			lacc_q <= lacc_q + lt_term - lb_term;
		end
	end

	// Result word register and its one-cycle strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rdiv_done;
		end
	end

	always_ff @(posedge clk) begin
		if (rdiv_done) begin
			rtilt_q <= rv_q ? rquot : '0;
			ltilt_q <= lv_q ? lquot : '0;
		end
	end

	assign done        = done_q;
	assign right_tilt  = rtilt_q;
	assign left_tilt   = ltilt_q;
	assign right_valid = rv_q;
	assign left_valid  = lv_q;

`ifndef ASSERT_OFF
	a_done_idle : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while the controller is busy");

	a_end_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && scan_end) |=> busy)
		else $error("last word of a scan did not start the drain");

	a_div_lockstep : assert property (@(posedge clk) disable iff (!arst_n)
		rdiv_done == ldiv_done)
		else $error("side dividers out of step");

	a_div_state : assert property (@(posedge clk) disable iff (!arst_n)
		rdiv_done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside the divide phase");

	a_invalid_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(done && !right_valid) |-> (right_tilt == '0))
		else $error("right tilt nonzero without enough points");
`endif

endmodule
